### design/indexed_list_table_engine_top_assert.svh
// Assertion macros for the list engine.
`ifndef INDEXED_LIST_TABLE_ENGINE_TOP_ASSERT_SVH
`define INDEXED_LIST_TABLE_ENGINE_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define ILT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ILT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ILT_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ILT_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

### design/ilte_pkg.sv
package ilte_pkg;
  localparam int unsigned Capacity = 64;
  localparam int unsigned FractionBits = 16;
  localparam int unsigned AddrW = $clog2(Capacity);
  localparam int unsigned CountW = $clog2(Capacity + 1);
  localparam int unsigned MeanW = 48;
  localparam int unsigned SumW = 72;
  localparam int unsigned TermW = 63;
  localparam int unsigned MagW = 32;
  localparam int unsigned NumW = CountW + 62 + FractionBits;
  localparam int unsigned QuotW = NumW;

  localparam logic [2:0] CmdInsert = 3'd0;
  localparam logic [2:0] CmdRemoveAt = 3'd1;
  localparam logic [2:0] CmdRemoveVal = 3'd2;
  localparam logic [2:0] CmdChange = 3'd3;
  localparam logic [2:0] CmdReverse = 3'd4;
  localparam logic [2:0] CmdMean = 3'd5;

  localparam logic [1:0] StatDone = 2'd0;
  localparam logic [1:0] StatIgnored = 2'd1;
  localparam logic [1:0] StatFull = 2'd2;
  localparam logic [1:0] StatUndef = 2'd3;

  typedef struct packed {
    logic [2:0] command;
    logic signed [7:0] position;
    logic signed [31:0] item_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [6:0] entry_count;
    logic signed [47:0] mean_fixed;
  } out_item_t;

  // Divider control between sequencer and shared divider.
  typedef struct packed {
    logic start;
    logic [NumW-1:0] num;
    logic [SumW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic [QuotW-1:0] quot;
  } div_rsp_t;
endpackage

### design/ilte_div.sv
module ilte_div import ilte_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);
  localparam int unsigned CntW = $clog2(NumW + 1);
  localparam int unsigned RemW = SumW + 1;

  logic [NumW-1:0] num_q, num_d;
  logic [SumW-1:0] den_q, den_d;
  logic [RemW-1:0] rem_q, rem_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic busy_q, busy_d, done_q, done_d;
  logic [RemW-1:0] shifted, diff;

  always_comb begin
    num_d = num_q;
    den_d = den_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    shifted = {rem_q[RemW-2:0], num_q[NumW-1]};
    diff = shifted - {1'b0, den_q};
    if (req_i.start) begin
      num_d = req_i.num;
      den_d = req_i.den;
      rem_d = '0;
      cnt_d = CntW'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // one restoring step: shift in a numerator bit, record the quotient bit
      if (!diff[RemW-1]) begin
        rem_d = diff;
        num_d = {num_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = shifted;
        num_d = {num_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = num_q;
endmodule

### design/indexed_list_table_engine_top.sv
// Channel | Signals                          | Direction
// in      | in_valid_i, in_ready_o, in_item_i  | item into the block
// out     | out_valid_o, out_ready_i, out_item_o | one result item per command
//
// Change, bad indices and unknown codes go from acceptance straight to the result.
// Insert moves the entries above the slot up one at a time, remove and search
// walk the entries one by one, and reverse swaps the entries pair by pair.
// The mean reads each entry and runs the shared divider (85 steps) for its
// reciprocal, then once more for the quotient.
// Reset clears the length and the sequencer; the store is not cleared.
// in_ready_o is low from acceptance until the result item is taken; a stalled
// output holds the result item and the block.
`include "indexed_list_table_engine_top_assert.svh"
module indexed_list_table_engine_top import ilte_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);
  typedef enum logic [3:0] {
    StIdle, StDecode, StSearchRd, StSearchCmp, StShiftRd, StShiftWr,
    StRevRdA, StRevRdB, StRevWrA, StRevWrB, StMeanRd, StMeanChk,
    StMeanDiv, StFinalDiv, StOut
  } state_e;

  // store: one write and one read port, registered read data
  logic [31:0] mem_q [Capacity];
  logic        we;
  logic [AddrW-1:0] waddr, raddr;
  logic [31:0] wdata, rdata_q;

  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    rdata_q <= mem_q[raddr];
  end

  state_e state_q;
  in_item_t item_q;
  logic [CountW-1:0] len_q, idx_q, jdx_q;
  logic [31:0] tmp_q;
  logic [SumW-1:0] sum_q;
  logic neg_q, xneg_q;
  logic [1:0] stat_q;
  logic signed [MeanW-1:0] mean_q;
  logic shift_up_q;

  div_req_t dreq;
  div_rsp_t drsp;
  ilte_div u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  // index resolution (narrow signed adds)
  logic signed [CountW+1:0] pos_s, len_s, ins_r, chg_r;
  always_comb begin
    pos_s = (CountW+2)'(in_item_i.position);
    len_s = {2'b00, len_q};
    ins_r = (in_item_i.position < 0) ? len_s + pos_s + (CountW+2)'(1) : pos_s;
    chg_r = (in_item_i.position < 0) ? len_s + pos_s : pos_s;
  end

  logic [31:0] mag;
  logic [TermW-1:0] term;
  logic [SumW-1:0] sum_abs;
  always_comb begin
    mag = rdata_q[31] ? (32'd0 - rdata_q) : rdata_q;
    term = drsp.quot[TermW-1:0];
    sum_abs = sum_q[SumW-1] ? (SumW'(0) - sum_q) : sum_q;
  end

  always_comb begin
    dreq = '0;
    we = 1'b0;
    waddr = idx_q[AddrW-1:0];
    wdata = tmp_q;
    raddr = idx_q[AddrW-1:0];
    if (state_q == StMeanChk && rdata_q != 32'd0) begin
      dreq.start = 1'b1;
      dreq.num = NumW'({1'b1, 62'd0});
      dreq.den = SumW'(mag);
    end
    unique case (state_q)
      StShiftWr: begin
        we = 1'b1;
        waddr = shift_up_q ? idx_q[AddrW-1:0] + AddrW'(1) : jdx_q[AddrW-1:0];
        wdata = rdata_q;
      end
      StShiftRd: raddr = idx_q[AddrW-1:0];
      StRevRdB: raddr = jdx_q[AddrW-1:0];
      StRevWrA: begin
        we = 1'b1;
        waddr = idx_q[AddrW-1:0];
        wdata = rdata_q;
      end
      StRevWrB: begin
        we = 1'b1;
        waddr = jdx_q[AddrW-1:0];
      end
      StIdle: begin
        if (in_valid_i && in_item_i.command == CmdChange && chg_r >= 0
            && chg_r < len_s) begin
          we = 1'b1;
          waddr = chg_r[AddrW-1:0];
          wdata = in_item_i.item_value;
        end
      end
      StDecode: begin
        // insert at the resolved slot once shifting is done
        if (item_q.command == CmdInsert) begin
          we = (idx_q == jdx_q);
          waddr = jdx_q[AddrW-1:0];
          wdata = item_q.item_value;
        end
      end
      default: ;
    endcase
    if (state_q == StFinalDiv && !drsp.busy && !drsp.done) begin
      dreq.start = 1'b1;
      dreq.num = NumW'(len_q) << (62 + FractionBits);
      dreq.den = sum_abs;
    end
  end

  logic [QuotW-1:0] q;
  assign q = drsp.quot;
  logic fin_go_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      len_q <= '0;
      fin_go_q <= 1'b0;
    end else begin
      unique case (state_q)
        StIdle: if (in_valid_i) begin
          item_q <= in_item_i;
          stat_q <= StatIgnored;
          mean_q <= '0;
          state_q <= StOut;
          unique case (in_item_i.command)
            CmdInsert: begin
              if (ins_r >= 0 && ins_r <= len_s) begin
                if (len_q >= CountW'(Capacity)) stat_q <= StatFull;
                else begin
                  stat_q <= StatDone;
                  // walk from the end down to the slot
                  idx_q <= len_q;
                  jdx_q <= ins_r[CountW-1:0];
                  shift_up_q <= 1'b1;
                  state_q <= StDecode;
                end
              end
            end
            CmdRemoveAt: begin
              if (in_item_i.position >= 0 && pos_s < len_s) begin
                stat_q <= StatDone;
                jdx_q <= pos_s[CountW-1:0];
                idx_q <= pos_s[CountW-1:0] + 1'b1;
                shift_up_q <= 1'b0;
                state_q <= StShiftRd;
              end
            end
            CmdRemoveVal: begin
              idx_q <= '0;
              state_q <= StSearchRd;
            end
            CmdChange: if (chg_r >= 0 && chg_r < len_s) stat_q <= StatDone;
            CmdReverse: begin
              stat_q <= StatDone;
              idx_q <= '0;
              jdx_q <= len_q - 1'b1;
              state_q <= StRevRdA;
            end
            CmdMean: begin
              stat_q <= StatDone;
              idx_q <= '0;
              sum_q <= '0;
              state_q <= (len_q == '0) ? StOut : StMeanRd;
            end
            default: ;
          endcase
        end
        StDecode: begin
          // insert: move entry idx-1 up to idx until the slot is reached
          if (idx_q == jdx_q) begin
            len_q <= len_q + 1'b1;
            state_q <= StOut;
          end else begin
            idx_q <= idx_q - 1'b1;
            state_q <= StShiftRd;
          end
        end
        StSearchRd: state_q <= (idx_q == len_q) ? StOut : StSearchCmp;
        StSearchCmp: begin
          if (rdata_q == item_q.item_value) begin
            stat_q <= StatDone;
            jdx_q <= idx_q;
            idx_q <= idx_q + 1'b1;
            shift_up_q <= 1'b0;
            state_q <= StShiftRd;
          end else begin
            idx_q <= idx_q + 1'b1;
            state_q <= StSearchRd;
          end
        end
        StShiftRd: begin
          if (!shift_up_q && idx_q >= len_q) begin
            len_q <= len_q - 1'b1;
            state_q <= StOut;
          end else state_q <= StShiftWr;
        end
        StShiftWr: begin
          if (shift_up_q) begin
            state_q <= StDecode;
          end else begin
            jdx_q <= idx_q;
            idx_q <= idx_q + 1'b1;
            state_q <= StShiftRd;
          end
        end
        StRevRdA: begin
          if (len_q < CountW'(2) || idx_q >= jdx_q) state_q <= StOut;
          else state_q <= StRevRdB;
        end
        StRevRdB: begin
          tmp_q <= rdata_q;
          state_q <= StRevWrA;
        end
        StRevWrA: state_q <= StRevWrB;
        StRevWrB: begin
          idx_q <= idx_q + 1'b1;
          jdx_q <= jdx_q - 1'b1;
          state_q <= StRevRdA;
        end
        StMeanRd: state_q <= StMeanChk;
        StMeanChk: begin
          if (rdata_q == 32'd0) begin
            mean_q <= '0;
            state_q <= StOut;
          end else begin
            xneg_q <= rdata_q[31];
            state_q <= StMeanDiv;
          end
        end
        StMeanDiv: if (drsp.done) begin
          sum_q <= sum_q + (xneg_q ? SumW'(0) - SumW'(term) : SumW'(term));
          if (idx_q + 1'b1 == len_q) begin
            fin_go_q <= 1'b0;
            state_q <= StFinalDiv;
          end else begin
            idx_q <= idx_q + 1'b1;
            state_q <= StMeanRd;
          end
        end
        StFinalDiv: begin
          if (sum_q == '0) begin
            stat_q <= StatUndef;
            state_q <= StOut;
          end else if (!fin_go_q) begin
            fin_go_q <= 1'b1;
            neg_q <= sum_q[SumW-1];
          end else if (drsp.done) begin
            // saturate to the signed mean range
            if (neg_q) begin
              if (q > QuotW'({1'b1, {(MeanW-1){1'b0}}}))
                mean_q <= {1'b1, {(MeanW-1){1'b0}}};
              else mean_q <= MeanW'(QuotW'(0) - q);
            end else begin
              if (q > QuotW'({(MeanW-1){1'b1}})) mean_q <= {1'b0, {(MeanW-1){1'b1}}};
              else mean_q <= q[MeanW-1:0];
            end
            state_q <= StOut;
          end
        end
        StOut: if (out_ready_i) state_q <= StIdle;
        default: state_q <= StIdle;
      endcase
    end
  end

  assign in_ready_o = (state_q == StIdle);
  assign out_valid_o = (state_q == StOut);
  assign out_item_o.status = stat_q;
  assign out_item_o.entry_count = 7'(len_q);
  assign out_item_o.mean_fixed = mean_q;

  `ILT_ASSERT_IMP(a_len_cap, clk_i, rst_ni, 1'b1, len_q <= CountW'(Capacity))
  `ILT_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_item_o))
  `ILT_ASSERT_IMP(a_mean_other, clk_i, rst_ni, out_valid_o && item_q.command != CmdMean, mean_q == '0)
endmodule
